// ----- hdl/lkvc_pkg.sv -----
// lkvc_pkg: shared types and constants of the lru key-value cache
// holds the request/response payload structs, the entry and link structs of the cell row
// and the control struct from the sequencer to the cells; no dependencies
package lkvc_pkg;

  // field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // default number of cells and reset value of the capacity register
  localparam int unsigned DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  // one request
  typedef struct packed {
    logic kind;
    key_t key;
    val_t value;
  } req_t;

  // one response
  typedef struct packed {
    logic hit;
    val_t read_value;
    logic evicted;
  } rsp_t;

  // contents of one cell
  typedef struct packed {
    logic valid;
    key_t key;
    val_t value;
  } entry_t;

  // search chain handed from cell to cell
  typedef struct packed {
    logic found;
    val_t fval;
  } link_t;

  // update control broadcast to every cell
  typedef struct packed {
    logic upd;
    logic hit;
    logic evict;
  } ctl_t;

endpackage

// ----- hdl/lkvc_cell.sv -----
// lkvc_cell: one cell of the recency-ordered entry row
// compares its key with the request, passes the search chain on, shifts on update
// depends on lkvc_pkg
module lkvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkvc_pkg::key_t  req_key_i,
  input  lkvc_pkg::ctl_t  ctl_i,
  input  lkvc_pkg::entry_t prev_entry_i,
  input  lkvc_pkg::link_t prev_link_i,
  output lkvc_pkg::entry_t entry_o,
  output lkvc_pkg::link_t link_o
);
  import lkvc_pkg::*;

  logic   valid_q;
  key_t   key_q;
  val_t   value_q;
  logic   found_q;
  val_t   fval_q;
  logic   match;
  logic   shift;

  // local key compare
  assign match = valid_q && (key_q == req_key_i);

  // hit: cells up to the matching one move down; miss: valid cells move down,
  // plus the first free cell when nothing is evicted
  assign shift = ctl_i.hit ? !prev_link_i.found
                           : (valid_q || (!ctl_i.evict && prev_entry_i.valid));

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.upd && shift) begin
      valid_q <= prev_entry_i.valid;
    end
  end

  // key and value
  always_ff @(posedge clk_i) begin
    if (ctl_i.upd && shift) begin
      key_q   <= prev_entry_i.key;
      value_q <= prev_entry_i.value;
    end
  end

  // search chain, settles one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= prev_link_i.found || match;
    end
  end

  always_ff @(posedge clk_i) begin
    fval_q <= match ? value_q : prev_link_i.fval;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign link_o  = '{found: found_q, fval: fval_q};

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// lru_key_value_cache: top level of the fully associative lru key-value cache
// a sequencer around a row of lkvc_cell instances; depends on lkvc_pkg and lkvc_cell
//
// Usage
//   Request channel in_valid_i / in_stall_o / in_req_i carries a lookup or a store
//   of one key. Response channel out_valid_o / out_stall_i / out_rsp_o returns one
//   response per request, in order: hit, value read on a lookup hit, eviction flag.
//   The user writes the capacity register only while idle; the block does not check.
// Timing
//   The entries sit in a row of DEPTH cells ordered by recency. A request is
//   searched by a chain that moves one cell per cycle; the response is written
//   once the chain has passed the last cell, and a new request is taken only
//   after that response write, back in idle.
//   The entry row is reordered in the same cycle as the response write.
// Reset
//   Clears all valid bits, the entry count and the output valid bit, and loads
//   the capacity with 16. No clearing pass is needed.
// Stall
//   The response register holds while out_stall_i is high; a finished request
//   waits for it, and in_stall_o stays high until that response is written.
module lru_key_value_cache #(
  parameter int unsigned DEPTH = lkvc_pkg::DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lkvc_pkg::req_t            in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lkvc_pkg::rsp_t            out_rsp_o
);
  import lkvc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH);
  localparam int unsigned NUM_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (NUM_W > CAP_W) ? NUM_W : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [CAP_W-1:0] cap_q;
  req_t             req_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_rsp_q, out_rsp_d;

  entry_t           ent [DEPTH];
  link_t            lnk [DEPTH];
  entry_t           head_entry;
  ctl_t             ctl;
  logic             accept;
  logic             fire;
  logic             hit;
  logic             is_store;
  logic             full;
  logic [CAP_W-1:0] cap_eff;
  val_t             found_val;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ST_IDLE);
  assign fire     = (st_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign hit      = lnk[DEPTH-1].found;
  assign found_val = lnk[DEPTH-1].fval;
  assign is_store = (req_q.kind == KIND_STORE);

  // capacity zero counts as one; above DEPTH is caught by the full-row compare
  assign cap_eff = (cap_q == '0) ? CAP_W'(1) : cap_q;
  assign full    = (CMP_W'(num_q) >= CMP_W'(cap_eff)) || (num_q == NUM_W'(DEPTH));

  // broadcast control to the cell row
  assign ctl.upd   = fire && (hit || is_store);
  assign ctl.hit   = hit;
  assign ctl.evict = full;

  // entry that enters at the most recent end
  assign head_entry = '{valid: 1'b1, key: req_q.key,
                        value: is_store ? req_q.value : found_val};

  // row of cells, each fed by its neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    link_t  prev_link;
    if (i == 0) begin : g_head
      assign prev_entry = head_entry;
      assign prev_link  = '{found: 1'b0, fval: '0};
    end else begin : g_body
      assign prev_entry = ent[i-1];
      assign prev_link  = lnk[i-1];
    end
    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .req_key_i    (req_q.key),
      .ctl_i        (ctl),
      .prev_entry_i (prev_entry),
      .prev_link_i  (prev_link),
      .entry_o      (ent[i]),
      .link_o       (lnk[i])
    );
  end

  // sequencer
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d  = ST_SCAN;
          cnt_d = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fire) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // entry count
  always_comb begin
    num_d = num_q;
    if (fire && is_store && !hit && !full) begin
      num_d = num_q + NUM_W'(1);
    end
  end

  // response register
  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (fire) begin
      out_valid_d          = 1'b1;
      out_rsp_d.hit        = hit;
      out_rsp_d.read_value = (hit && !is_store) ? found_val : '0;
      out_rsp_d.evicted    = is_store && !hit && full;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      num_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      num_q       <= num_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- hdl/lkvc_checker.sv -----
// lkvc_checker: port-level checks of the lru key-value cache
// sees only the top level's ports; bound to lru_key_value_cache; depends on lkvc_pkg
module lkvc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  lkvc_pkg::req_t            in_req_i,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  lkvc_pkg::rsp_t            out_rsp_o
);
  import lkvc_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ (|cfg_wdata_i) ^ (|in_req_i);

  // a request just taken keeps the request side busy for the search
  a_busy_after_req: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o)
    else $error("request side free too soon after a request");

  // an eviction is never reported together with a hit
  a_evict_no_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.evicted && out_rsp_o.hit))
    else $error("eviction reported together with a hit");

  // a read value only comes from a hit, never with an eviction
  a_value_needs_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.read_value != '0)) |-> (out_rsp_o.hit && !out_rsp_o.evicted))
    else $error("read value without a lookup hit");

  // a stalled response holds
  a_rsp_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- tb/lkvc_checker.sv -----
// lkvc_tb_checker: watches both channels and the capacity port of the lru key-value cache,
// predicts each response from its own recency-ordered copy of the entries and compares.
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_tb_checker #(
  parameter int unsigned DEPTH = lkvc_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  lkvc_pkg::req_t             in_req_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  lkvc_pkg::rsp_t             out_rsp_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o
);
  import lkvc_pkg::*;

  // one cached line
  typedef struct {
    key_t key;
    val_t value;
  } line_t;

  // cached lines, most recent first
  line_t            recency_order[$];
  // responses still owed by the block, oldest first
  rsp_t             awaited_rsp[$];
  logic [CAP_W-1:0] capacity_q = CAP_RESET;
  int unsigned      mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // apply one request to the cached lines and return the response it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t  p;
    line_t ln;
    int    idx;
    int    limit;
    p   = '0;
    idx = -1;
    foreach (recency_order[i]) begin
      if (idx < 0 && recency_order[i].key == r.key) idx = i;
    end
    // zero capacity behaves as one, anything past the row as the full row
    limit = int'(capacity_q);
    if (limit == 0) limit = 1;
    if (limit > int'(DEPTH)) limit = DEPTH;
    if (idx >= 0) begin
      ln = recency_order[idx];
      recency_order.delete(idx);
      p.hit = 1'b1;
      if (r.kind == KIND_LOOKUP) begin
        p.read_value = ln.value;
      end else begin
        ln.value = r.value;
      end
      recency_order.push_front(ln);
    end else if (r.kind == KIND_STORE) begin
      // a full (or over-full after a capacity drop) cache loses its oldest line
      if (recency_order.size() >= limit) begin
        void'(recency_order.pop_back());
        p.evicted = 1'b1;
      end
      ln.key   = r.key;
      ln.value = r.value;
      recency_order.push_front(ln);
    end
    return p;
  endfunction

  // track config, check responses, then queue the prediction for a new request
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      recency_order.delete();
      awaited_rsp.delete();
      capacity_q = CAP_RESET;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = awaited_rsp.pop_front();
          if (out_rsp_i.hit !== want.hit) begin
            report_mismatch($sformatf("hit %b, expected %b", out_rsp_i.hit, want.hit));
          end
          if (out_rsp_i.read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value %h, expected %h",
                                      out_rsp_i.read_value, want.read_value));
          end
          if (out_rsp_i.evicted !== want.evicted) begin
            report_mismatch($sformatf("evicted %b, expected %b",
                                      out_rsp_i.evicted, want.evicted));
          end
        end
      end
      if (in_valid_i && !in_stall_i) awaited_rsp.push_back(apply_request(in_req_i));
      pending_o <= awaited_rsp.size();
    end
  end

endmodule

// ----- tb/tb_lru_key_value_cache.sv -----
// tb_lru_key_value_cache: top of the lru key-value cache testbench
// drives lookups, stores and capacity writes with bursty traffic and receiver stalls;
// depends on lkvc_pkg, lru_key_value_cache and lkvc_tb_checker
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned PHASE_COUNT     = 10;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned POOL_MAX        = DEPTH_DEF + 4;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  req_t             in_req    = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsp_t             out_rsp;
  int unsigned      mismatches;
  int unsigned      pending;
  int unsigned      cycle_count = 0;

  // keys reused within a phase so that hits and evictions both happen
  key_t             key_pool[POOL_MAX];
  int unsigned      pool_size = DEPTH_DEF + 3;

  stall_mode_e      stall_mode = STALL_NONE;
  int unsigned      mode_left  = 0;

  lru_key_value_cache u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  lkvc_tb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls in stretches of none, light and heavy back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(2, 0));
        mode_left  = $urandom_range(300, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
        default:     out_stall <= ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  // present one request and hold it until taken
  task automatic issue(logic kind, key_t key, val_t value);
    in_valid     <= 1'b1;
    in_req.kind  <= kind;
    in_req.key   <= key;
    in_req.value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every owed response
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // capacity change, only with the block idle; key pool sized to the new setting
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    int unsigned eff;
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff = (cap == '0) ? 1 : ((cap > CAP_W'(DEPTH_DEF)) ? DEPTH_DEF : 32'(cap));
    pool_size = eff + 3;
    foreach (key_pool[i]) key_pool[i] = $urandom();
  endtask

  initial begin
    logic [CAP_W-1:0] phase_cap[PHASE_COUNT];
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      gap;
    key_t             key;

    phase_cap = '{5'd1, 5'd16, 5'd0, 5'd2, 5'd31, 5'd17, 5'd8, 5'd3, 5'd16, 5'd0};
    phase_cap[PHASE_COUNT-1] = CAP_W'($urandom_range(31, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: miss on empty, extreme keys and values, overwrite
    issue(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(KIND_STORE,  32'h0000_0000, 32'h0000_0000);
    issue(KIND_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    issue(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(KIND_STORE,  32'h0000_0000, 32'hA5A5_A5A5);
    issue(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue(KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000);

    // capacity below the count: every new store evicts the oldest line
    set_capacity(5'd1);
    issue(KIND_STORE,  32'h0000_0001, 32'h0000_0001);
    issue(KIND_STORE,  32'h0000_0002, 32'h5A5A_5A5A);
    issue(KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    issue(KIND_LOOKUP, 32'h0000_0002, 32'h0000_0000);

    // zero capacity acts as one
    set_capacity(5'd0);
    issue(KIND_STORE,  32'h0000_0003, 32'hDEAD_BEEF);
    issue(KIND_LOOKUP, 32'h0000_0002, 32'h0000_0000);
    issue(KIND_LOOKUP, 32'h0000_0003, 32'h0000_0000);
    issue(KIND_STORE,  32'h0000_0003, 32'h0F0F_0F0F);

    // capacity past the row saturates
    set_capacity(5'd31);
    issue(KIND_STORE,  32'h8000_0000, 32'h8000_0000);
    issue(KIND_STORE,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(KIND_LOOKUP, 32'h0000_0003, 32'h0000_0000);
    issue(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);

    // random phases, each at its own capacity, bursty sender
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      set_capacity(phase_cap[ph]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(8, 1);
        for (int unsigned b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
          key = ($urandom_range(9, 0) < 8) ? key_pool[$urandom_range(pool_size - 1, 0)]
                                            : key_t'($urandom());
          issue(logic'($urandom_range(1, 0)), key, val_t'($urandom()));
          sent++;
        end
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(25, 1);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        // now and then let the block run completely dry mid-phase
        if ($urandom_range(39, 0) == 0) quiesce();
      end
    end

    // drain and let any stray response show up
    quiesce();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache.sv
hdl/lkvc_checker.sv
tb/lkvc_checker.sv
tb/tb_lru_key_value_cache.sv
